>>> design/pats_pkg.sv
// ----------------------------------------------------------------------------
// pats_pkg
// Shared types, phase codes and register indexes of the PWM/ADC test
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pats_pkg;

  // time base width, deadlines compare unsigned and wrap
  localparam int unsigned TimeBits = 32;
  localparam int unsigned MvBits   = 16;
  localparam int unsigned HoldBits = 24;
  localparam int unsigned DutyBits = 7;
  localparam int unsigned CntBits  = 32;
  localparam int unsigned CodeBits = 3;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [MvBits-1:0]   mv_t;
  typedef logic [HoldBits-1:0] hold_t;
  typedef logic [DutyBits-1:0] duty_t;
  typedef logic [CntBits-1:0]  cnt_t;
  typedef logic [CodeBits-1:0] code_t;

  // main phase codes
  localparam code_t PhInit  = 3'd0;
  localparam code_t PhIdle  = 3'd1;
  localparam code_t PhRun   = 3'd2;
  localparam code_t PhStep1 = 3'd3;
  localparam code_t PhStep2 = 3'd4;
  localparam code_t PhStep3 = 3'd5;
  localparam code_t PhDone  = 3'd6;

  // step sub-phase codes
  localparam code_t SpNone   = 3'd0;
  localparam code_t SpOn     = 3'd1;
  localparam code_t SpWait   = 3'd2;
  localparam code_t SpSample = 3'd3;
  localparam code_t SpOff    = 3'd4;

  // configuration register indexes
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgRefMv     = 3'd0;
  localparam cfg_idx_t CfgInitHold  = 3'd1;
  localparam cfg_idx_t CfgSettle    = 3'd2;
  localparam cfg_idx_t CfgDoneHold  = 3'd3;
  localparam cfg_idx_t CfgIdleHold  = 3'd4;
  localparam cfg_idx_t CfgDuty      = 3'd5;

  localparam duty_t DutyMax = 7'd100;

  // one result item
  typedef struct packed {
    code_t phase;
    code_t sub_phase;
    logic  pwm0_on;
    logic  pwm1_on;
    duty_t duty_out;
    logic  sample_taken;
    logic  sample_channel;
    logic  ch0_abnormal;
    logic  ch1_abnormal;
    cnt_t  error_total;
    cnt_t  cycles_started;
  } result_t;

endpackage

`default_nettype wire

>>> design/pats_if.sv
// ----------------------------------------------------------------------------
// pats_in_if / pats_out_if
// Valid/ready channels carrying poll items in and result items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pats_in_if;
  logic               valid;
  logic               ready;
  pats_pkg::time_t    now_time;
  pats_pkg::mv_t      sample_mv;

  modport source (output valid, output now_time, output sample_mv, input ready);
  modport sink   (input valid, input now_time, input sample_mv, output ready);
endinterface

interface pats_out_if;
  logic               valid;
  logic               ready;
  pats_pkg::code_t    phase;
  pats_pkg::code_t    sub_phase;
  logic               pwm0_on;
  logic               pwm1_on;
  pats_pkg::duty_t    duty_out;
  logic               sample_taken;
  logic               sample_channel;
  logic               ch0_abnormal;
  logic               ch1_abnormal;
  pats_pkg::cnt_t     error_total;
  pats_pkg::cnt_t     cycles_started;

  modport source (
    output valid, output phase, output sub_phase, output pwm0_on, output pwm1_on,
    output duty_out, output sample_taken, output sample_channel,
    output ch0_abnormal, output ch1_abnormal, output error_total,
    output cycles_started, input ready
  );
  modport sink (
    input valid, input phase, input sub_phase, input pwm0_on, input pwm1_on,
    input duty_out, input sample_taken, input sample_channel,
    input ch0_abnormal, input ch1_abnormal, input error_total,
    input cycles_started, output ready
  );
endinterface

`default_nettype wire

>>> design/pwm_adc_test_sequencer_core.sv
// ----------------------------------------------------------------------------
// pwm_adc_test_sequencer_core
// Timed PWM/ADC test cycle: init, idle, three PWM steps with voltage check,
// done hold, back to idle. One result item per poll item.
// ----------------------------------------------------------------------------
// Each poll item (current time and a millivolt sample) advances the sequencer
// by one transition and yields one result item showing the state after that
// poll. The block takes one item per clock cycle as long as results are drained:
// the whole transition (deadline adds and unsigned compares) sits between the
// sequencer state registers and the result register, and the result is valid in
// the cycle after acceptance. The single-stage result register takes a new item
// whenever it is empty or being drained in the same cycle. Configuration is to be
// written through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module pwm_adc_test_sequencer_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [pats_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire  [pats_pkg::CfgDataBits-1:0]   cfg_data_i,
  pats_in_if.sink                            in_if,
  pats_out_if.source                         out_if
);

  // configuration registers
  pats_pkg::mv_t   ref_mv_q;
  pats_pkg::hold_t init_hold_q, settle_q, done_hold_q, idle_hold_q;
  pats_pkg::duty_t duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mv_q    <= 16'd3300;
      init_hold_q <= 24'd10000;
      settle_q    <= 24'd100;
      done_hold_q <= 24'd10000;
      idle_hold_q <= 24'd10000;
      duty_q      <= 7'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pats_pkg::CfgRefMv:    ref_mv_q    <= cfg_data_i[pats_pkg::MvBits-1:0];
        pats_pkg::CfgInitHold: init_hold_q <= cfg_data_i;
        pats_pkg::CfgSettle:   settle_q    <= cfg_data_i;
        pats_pkg::CfgDoneHold: done_hold_q <= cfg_data_i;
        pats_pkg::CfgIdleHold: idle_hold_q <= cfg_data_i;
        pats_pkg::CfgDuty:     duty_q      <= cfg_data_i[pats_pkg::DutyBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  pats_pkg::code_t phase_q, phase_d;
  pats_pkg::code_t sub_q, sub_d;
  pats_pkg::time_t deadline_q, deadline_d;
  pats_pkg::time_t settle_dl_q, settle_dl_d;
  logic [1:0]      pwm_q, pwm_d;
  logic [1:0]      verdict_q, verdict_d;
  pats_pkg::cnt_t  err_q, err_d;
  pats_pkg::cnt_t  run_q, run_d;
  logic            armed_q, armed_d;

  // handshake
  logic out_valid_q;
  logic in_fire;
  pats_pkg::result_t res_q, res_d;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // per-poll transition
  pats_pkg::time_t now;
  pats_pkg::time_t done_dl;
  logic            ch;
  logic            taken;
  logic            tch;
  pats_pkg::duty_t duty_clamped;

  assign now = in_if.now_time;
  assign ch  = (phase_q == pats_pkg::PhStep2);

  always_comb begin
    phase_d     = phase_q;
    sub_d       = sub_q;
    deadline_d  = deadline_q;
    settle_dl_d = settle_dl_q;
    pwm_d       = pwm_q;
    verdict_d   = verdict_q;
    err_d       = err_q;
    run_d       = run_q;
    armed_d     = armed_q;
    taken       = 1'b0;
    tch         = 1'b0;
    done_dl     = armed_q ? deadline_q
                          : now + pats_pkg::time_t'(done_hold_q);
    unique case (phase_q)
      pats_pkg::PhInit: begin
        pwm_d      = 2'b00;
        verdict_d  = 2'b00;
        err_d      = '0;
        run_d      = '0;
        sub_d      = pats_pkg::SpNone;
        armed_d    = 1'b0;
        phase_d    = pats_pkg::PhIdle;
        deadline_d = now + pats_pkg::time_t'(init_hold_q);
      end
      pats_pkg::PhIdle: begin
        if (now >= deadline_q) begin
          phase_d = pats_pkg::PhRun;
          sub_d   = pats_pkg::SpNone;
        end
      end
      pats_pkg::PhRun: begin
        phase_d = pats_pkg::PhStep1;
        sub_d   = pats_pkg::SpOn;
        run_d   = run_q + 1'b1;
      end
      pats_pkg::PhStep1, pats_pkg::PhStep2, pats_pkg::PhStep3: begin
        unique case (sub_q)
          pats_pkg::SpOn: begin
            pwm_d[ch]   = 1'b1;
            sub_d       = pats_pkg::SpWait;
            settle_dl_d = now + pats_pkg::time_t'(settle_q);
          end
          pats_pkg::SpWait: begin
            if (now >= settle_dl_q) sub_d = pats_pkg::SpSample;
          end
          pats_pkg::SpSample: begin
            taken = 1'b1;
            tch   = ch;
            if (in_if.sample_mv <= ref_mv_q) begin
              verdict_d[ch] = 1'b0;
            end else begin
              verdict_d[ch] = 1'b1;
              err_d         = err_q + 1'b1;
            end
            sub_d = pats_pkg::SpOff;
          end
          pats_pkg::SpOff: begin
            pwm_d[ch] = 1'b0;
            if (phase_q == pats_pkg::PhStep3) begin
              phase_d    = pats_pkg::PhDone;
              deadline_d = '0;
              armed_d    = 1'b0;
            end else begin
              phase_d = phase_q + 1'b1;
              sub_d   = pats_pkg::SpOn;
            end
          end
          default: begin
          end
        endcase
      end
      pats_pkg::PhDone: begin
        deadline_d = done_dl;
        armed_d    = 1'b1;
        if (now >= done_dl) begin
          phase_d    = pats_pkg::PhIdle;
          deadline_d = now + pats_pkg::time_t'(idle_hold_q);
          sub_d      = pats_pkg::SpNone;
          armed_d    = 1'b0;
        end
      end
      default: begin
        phase_d = pats_pkg::PhInit;
      end
    endcase
  end

  // result item assembly
  assign duty_clamped = (duty_q > pats_pkg::DutyMax) ? pats_pkg::DutyMax : duty_q;

  always_comb begin
    res_d.phase          = phase_d;
    res_d.sub_phase      = sub_d;
    res_d.pwm0_on        = pwm_d[0];
    res_d.pwm1_on        = pwm_d[1];
    res_d.duty_out       = (|pwm_d) ? duty_clamped : '0;
    res_d.sample_taken   = taken;
    res_d.sample_channel = tch;
    res_d.ch0_abnormal   = verdict_d[0];
    res_d.ch1_abnormal   = verdict_d[1];
    res_d.error_total    = err_d;
    res_d.cycles_started = run_d;
  end

  // state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pats_pkg::PhInit;
      sub_q       <= pats_pkg::SpNone;
      deadline_q  <= '0;
      settle_dl_q <= '0;
      pwm_q       <= 2'b00;
      verdict_q   <= 2'b00;
      err_q       <= '0;
      run_q       <= '0;
      armed_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      deadline_q  <= deadline_d;
      settle_dl_q <= settle_dl_d;
      pwm_q       <= pwm_d;
      verdict_q   <= verdict_d;
      err_q       <= err_d;
      run_q       <= run_d;
      armed_q     <= armed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.phase          = res_q.phase;
  assign out_if.sub_phase      = res_q.sub_phase;
  assign out_if.pwm0_on        = res_q.pwm0_on;
  assign out_if.pwm1_on        = res_q.pwm1_on;
  assign out_if.duty_out       = res_q.duty_out;
  assign out_if.sample_taken   = res_q.sample_taken;
  assign out_if.sample_channel = res_q.sample_channel;
  assign out_if.ch0_abnormal   = res_q.ch0_abnormal;
  assign out_if.ch1_abnormal   = res_q.ch1_abnormal;
  assign out_if.error_total    = res_q.error_total;
  assign out_if.cycles_started = res_q.cycles_started;

  // never both channels driven at once
  a_pwm_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pwm_q[0] && pwm_q[1]))
    else $error("both pwm channels on");

  // a sample is only taken on the way into pwm off
  a_sample_in_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.sample_taken) |-> (res_q.sub_phase == pats_pkg::SpOff))
    else $error("sample taken outside sample step");

  // duty shows only while a channel is driven
  a_duty_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.duty_out != '0) ->
                     (res_q.pwm0_on || res_q.pwm1_on)))
    else $error("duty without channel on");

  // a waiting result blocks the next item
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted over a stalled result");

  // outside init, the error count moves only with an abnormal judgement
  a_err_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (err_d != err_q) && (phase_q != pats_pkg::PhInit))
      |-> (taken && (err_d == err_q + 1'b1)))
    else $error("error count changed without a sample");

endmodule

`default_nettype wire
